// ----- design/rbp_pkg.sv -----
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared number format, constants and saturating fixed-point helpers for the
// relativistic Boris push pipeline.
// ----------------------------------------------------------------------------
package rbp_pkg;

  localparam int W       = 32;
  localparam int F       = 16;
  localparam int SQW     = W - 1 + F;
  localparam int SR      = (SQW + 1) / 2;
  localparam int DIV_LAT = W + 2;

  typedef logic signed [W-1:0]   word_t;
  typedef word_t [2:0]           vec_t;
  typedef logic signed [2*W+1:0] wide_t;

  localparam word_t FX_ONE  = word_t'(2 ** F);
  localparam word_t FX_HALF = word_t'(2 ** (F - 1));
  localparam word_t FX_TWO  = word_t'(2 ** (F + 1));

  localparam wide_t WMAX     = wide_t'({1'b0, {(W-1){1'b1}}});
  localparam wide_t WMIN     = -WMAX - wide_t'(1);
  localparam word_t WORD_MAX = word_t'(WMAX);
  localparam word_t WORD_MIN = word_t'(WMIN);

  function automatic word_t sat(input wide_t v);
    if (v > WMAX) begin
      return WORD_MAX;
    end
    if (v < WMIN) begin
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  function automatic word_t fadd(input word_t a, input word_t b);
    return sat(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t fsub(input word_t a, input word_t b);
    return sat(wide_t'(a) - wide_t'(b));
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic word_t fmul(input word_t a, input word_t b);
    logic signed [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b);
    p = (p + ((2*W)'(1) <<< (F - 1))) >>> F;
    return sat(wide_t'(p));
  endfunction

endpackage

// ----- design/relativistic_boris_push_core.sv -----
// ----------------------------------------------------------------------------
// relativistic_boris_push_core
// Fixed-point relativistic Boris particle push, one particle per item.
// ----------------------------------------------------------------------------
// Takes one particle per cycle while in_ready is high and returns it in the
// default Q15.16 format. Its depth comes from two 24-stage square-root
// pipelines (one root bit per stage) and three 34-stage divider pipelines
// (one quotient bit per stage) in series with the multiply and add stages.
// The whole pipeline advances together; an output register plus one skid
// register let input keep flowing while a result waits, and the pipeline
// holds only once both are occupied.
module relativistic_boris_push_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [rbp_pkg::W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rbp_pkg::word_t        vel_x,
  input  rbp_pkg::word_t        vel_y,
  input  rbp_pkg::word_t        vel_z,
  input  rbp_pkg::word_t        efield_x,
  input  rbp_pkg::word_t        efield_y,
  input  rbp_pkg::word_t        efield_z,
  input  rbp_pkg::word_t        bfield_x,
  input  rbp_pkg::word_t        bfield_y,
  input  rbp_pkg::word_t        bfield_z,
  input  rbp_pkg::word_t        pos_x,
  input  rbp_pkg::word_t        pos_y,
  input  rbp_pkg::word_t        pos_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [rbp_pkg::W-2:0] lorentz_factor,
  output rbp_pkg::word_t        new_vel_x,
  output rbp_pkg::word_t        new_vel_y,
  output rbp_pkg::word_t        new_vel_z,
  output rbp_pkg::word_t        new_pos_x,
  output rbp_pkg::word_t        new_pos_y,
  output rbp_pkg::word_t        new_pos_z
);

  localparam int W  = rbp_pkg::W;
  localparam int SR = rbp_pkg::SR;

  localparam logic CFG_CHARGE_TO_MASS = 1'b0;
  localparam logic CFG_TIME_STEP      = 1'b1;

  localparam int NX [3] = '{1, 2, 0};
  localparam int NZ [3] = '{2, 0, 1};

  typedef rbp_pkg::word_t word_t;
  typedef rbp_pkg::vec_t  vec_t;
  typedef logic [SR-1:0]  root_t;

  typedef struct packed { logic v; vec_t u, e, b, x; word_t m1; } s1_t;
  typedef struct packed { logic v; vec_t u, e, b, x; word_t hh; } s2_t;
  typedef struct packed { logic v; vec_t u, me, hb, x; } s3_t;
  typedef struct packed { logic v; vec_t um, me, hb, x; } s4_t;
  typedef struct packed { logic v; vec_t sq, um, me, hb, x; } s5_t;
  typedef struct packed { logic v; word_t a01, sq2; vec_t um, me, hb, x; } s6_t;
  typedef struct packed { logic v; word_t r; vec_t um, me, hb, x; } s7_t;
  typedef struct packed { vec_t um, me, hb, x; } side1_t;
  typedef struct packed { vec_t um, me, x; } side2_t;
  typedef struct packed { logic v; vec_t tt, t2, ca, cb, um, me, x; } s8_t;
  typedef struct packed { logic v; word_t t01, tt2; vec_t t2, cr, um, me, x; } s9_t;
  typedef struct packed { logic v; word_t den; vec_t t2, up, um, me, x; } s10_t;
  typedef struct packed { vec_t up, um, me, x; } side3_t;
  typedef struct packed { logic v; vec_t pa, pb, um, me, x; } s11_t;
  typedef struct packed { logic v; vec_t cr, um, me, x; } s12_t;
  typedef struct packed { logic v; vec_t un, x; } s13_t;
  typedef struct packed { logic v; vec_t sq, un, x; } s14_t;
  typedef struct packed { logic v; word_t a01, sq2; vec_t un, x; } s15_t;
  typedef struct packed { logic v; word_t r; vec_t un, x; } s16_t;
  typedef struct packed { vec_t un, x; } side4_t;
  typedef struct packed { logic v; root_t gam; vec_t dtu, un, x; } s17_t;
  typedef struct packed { root_t gam; vec_t un, x; } side5_t;
  typedef struct packed { root_t gam; vec_t un, np; } res_t;
  typedef struct packed { logic v; res_t res; } s18_t;

  word_t          charge_to_mass;
  logic [W-2:0]   time_step;
  word_t          dt_w;
  logic           en;

  s1_t  s1,  s1_next;
  s2_t  s2,  s2_next;
  s3_t  s3,  s3_next;
  s4_t  s4,  s4_next;
  s5_t  s5,  s5_next;
  s6_t  s6,  s6_next;
  s7_t  s7,  s7_next;
  s8_t  s8,  s8_next;
  s9_t  s9,  s9_next;
  s10_t s10, s10_next;
  s11_t s11, s11_next;
  s12_t s12, s12_next;
  s13_t s13, s13_next;
  s14_t s14, s14_next;
  s15_t s15, s15_next;
  s16_t s16, s16_next;
  s17_t s17, s17_next;
  s18_t s18, s18_next;

  side1_t d1_in, d1;
  side2_t d2_in, d2;
  side3_t d3_in, d3;
  side4_t d4_in, d4;
  side5_t d5_in, d5;
  logic   d1_valid, d2_valid, d3_valid, d4_valid, d5_valid;

  root_t gn, gam;
  vec_t  t_q, s_q, q_q;

  res_t out_reg, skid_reg;
  logic out_full, skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_to_mass <= rbp_pkg::FX_ONE;
      time_step      <= (W-1)'(rbp_pkg::FX_ONE);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_CHARGE_TO_MASS: charge_to_mass <= cfg_data;
        CFG_TIME_STEP:      time_step      <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  assign dt_w     = word_t'({1'b0, time_step});
  assign en       = !skid_full;
  assign in_ready = en;

  always_comb begin
    s1_next.v  = in_valid;
    s1_next.u  = {vel_z, vel_y, vel_x};
    s1_next.e  = {efield_z, efield_y, efield_x};
    s1_next.b  = {bfield_z, bfield_y, bfield_x};
    s1_next.x  = {pos_z, pos_y, pos_x};
    s1_next.m1 = rbp_pkg::fmul(charge_to_mass, dt_w);

    s2_next.v  = s1.v;
    s2_next.u  = s1.u;
    s2_next.e  = s1.e;
    s2_next.b  = s1.b;
    s2_next.x  = s1.x;
    s2_next.hh = rbp_pkg::fmul(s1.m1, rbp_pkg::FX_HALF);

    s3_next.v = s2.v;
    s3_next.u = s2.u;
    s3_next.x = s2.x;
    for (int d = 0; d < 3; d++) begin
      s3_next.me[d] = rbp_pkg::fmul(s2.e[d], s2.hh);
      s3_next.hb[d] = rbp_pkg::fmul(s2.hh, s2.b[d]);
    end

    s4_next.v  = s3.v;
    s4_next.me = s3.me;
    s4_next.hb = s3.hb;
    s4_next.x  = s3.x;
    for (int d = 0; d < 3; d++) begin
      s4_next.um[d] = rbp_pkg::fadd(s3.u[d], s3.me[d]);
    end

    s5_next.v  = s4.v;
    s5_next.um = s4.um;
    s5_next.me = s4.me;
    s5_next.hb = s4.hb;
    s5_next.x  = s4.x;
    for (int d = 0; d < 3; d++) begin
      s5_next.sq[d] = rbp_pkg::fmul(s4.um[d], s4.um[d]);
    end

    s6_next.v   = s5.v;
    s6_next.a01 = rbp_pkg::fadd(s5.sq[0], s5.sq[1]);
    s6_next.sq2 = s5.sq[2];
    s6_next.um  = s5.um;
    s6_next.me  = s5.me;
    s6_next.hb  = s5.hb;
    s6_next.x   = s5.x;

    s7_next.v  = s6.v;
    s7_next.r  = rbp_pkg::fadd(rbp_pkg::FX_ONE, rbp_pkg::fadd(s6.a01, s6.sq2));
    s7_next.um = s6.um;
    s7_next.me = s6.me;
    s7_next.hb = s6.hb;
    s7_next.x  = s6.x;

    d1_in.um = s7.um;
    d1_in.me = s7.me;
    d1_in.hb = s7.hb;
    d1_in.x  = s7.x;

    d2_in.um = d1.um;
    d2_in.me = d1.me;
    d2_in.x  = d1.x;

    s8_next.v  = d2_valid;
    s8_next.um = d2.um;
    s8_next.me = d2.me;
    s8_next.x  = d2.x;
    for (int d = 0; d < 3; d++) begin
      s8_next.tt[d] = rbp_pkg::fmul(t_q[d], t_q[d]);
      s8_next.t2[d] = rbp_pkg::fmul(rbp_pkg::FX_TWO, t_q[d]);
      s8_next.ca[d] = rbp_pkg::fmul(d2.um[NX[d]], t_q[NZ[d]]);
      s8_next.cb[d] = rbp_pkg::fmul(d2.um[NZ[d]], t_q[NX[d]]);
    end

    s9_next.v   = s8.v;
    s9_next.t01 = rbp_pkg::fadd(s8.tt[0], s8.tt[1]);
    s9_next.tt2 = s8.tt[2];
    s9_next.t2  = s8.t2;
    s9_next.um  = s8.um;
    s9_next.me  = s8.me;
    s9_next.x   = s8.x;
    for (int d = 0; d < 3; d++) begin
      s9_next.cr[d] = rbp_pkg::fsub(s8.ca[d], s8.cb[d]);
    end

    s10_next.v   = s9.v;
    s10_next.den = rbp_pkg::fadd(rbp_pkg::FX_ONE, rbp_pkg::fadd(s9.t01, s9.tt2));
    s10_next.t2  = s9.t2;
    s10_next.um  = s9.um;
    s10_next.me  = s9.me;
    s10_next.x   = s9.x;
    for (int d = 0; d < 3; d++) begin
      s10_next.up[d] = rbp_pkg::fadd(s9.um[d], s9.cr[d]);
    end

    d3_in.up = s10.up;
    d3_in.um = s10.um;
    d3_in.me = s10.me;
    d3_in.x  = s10.x;

    s11_next.v  = d3_valid;
    s11_next.um = d3.um;
    s11_next.me = d3.me;
    s11_next.x  = d3.x;
    for (int d = 0; d < 3; d++) begin
      s11_next.pa[d] = rbp_pkg::fmul(d3.up[NX[d]], s_q[NZ[d]]);
      s11_next.pb[d] = rbp_pkg::fmul(d3.up[NZ[d]], s_q[NX[d]]);
    end

    s12_next.v  = s11.v;
    s12_next.um = s11.um;
    s12_next.me = s11.me;
    s12_next.x  = s11.x;
    for (int d = 0; d < 3; d++) begin
      s12_next.cr[d] = rbp_pkg::fsub(s11.pa[d], s11.pb[d]);
    end

    s13_next.v = s12.v;
    s13_next.x = s12.x;
    for (int d = 0; d < 3; d++) begin
      s13_next.un[d] = rbp_pkg::fadd(rbp_pkg::fadd(s12.um[d], s12.cr[d]), s12.me[d]);
    end

    s14_next.v  = s13.v;
    s14_next.un = s13.un;
    s14_next.x  = s13.x;
    for (int d = 0; d < 3; d++) begin
      s14_next.sq[d] = rbp_pkg::fmul(s13.un[d], s13.un[d]);
    end

    s15_next.v   = s14.v;
    s15_next.a01 = rbp_pkg::fadd(s14.sq[0], s14.sq[1]);
    s15_next.sq2 = s14.sq[2];
    s15_next.un  = s14.un;
    s15_next.x   = s14.x;

    s16_next.v  = s15.v;
    s16_next.r  = rbp_pkg::fadd(rbp_pkg::FX_ONE, rbp_pkg::fadd(s15.a01, s15.sq2));
    s16_next.un = s15.un;
    s16_next.x  = s15.x;

    d4_in.un = s16.un;
    d4_in.x  = s16.x;

    s17_next.v   = d4_valid;
    s17_next.gam = gam;
    s17_next.un  = d4.un;
    s17_next.x   = d4.x;
    for (int d = 0; d < 3; d++) begin
      s17_next.dtu[d] = rbp_pkg::fmul(dt_w, d4.un[d]);
    end

    d5_in.gam = s17.gam;
    d5_in.un  = s17.un;
    d5_in.x   = s17.x;

    s18_next.v       = d5_valid;
    s18_next.res.gam = d5.gam;
    s18_next.res.un  = d5.un;
    for (int d = 0; d < 3; d++) begin
      s18_next.res.np[d] = rbp_pkg::fadd(d5.x[d], q_q[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.v  <= 1'b0;
      s2.v  <= 1'b0;
      s3.v  <= 1'b0;
      s4.v  <= 1'b0;
      s5.v  <= 1'b0;
      s6.v  <= 1'b0;
      s7.v  <= 1'b0;
      s8.v  <= 1'b0;
      s9.v  <= 1'b0;
      s10.v <= 1'b0;
      s11.v <= 1'b0;
      s12.v <= 1'b0;
      s13.v <= 1'b0;
      s14.v <= 1'b0;
      s15.v <= 1'b0;
      s16.v <= 1'b0;
      s17.v <= 1'b0;
      s18.v <= 1'b0;
    end else if (en) begin
      s1  <= s1_next;
      s2  <= s2_next;
      s3  <= s3_next;
      s4  <= s4_next;
      s5  <= s5_next;
      s6  <= s6_next;
      s7  <= s7_next;
      s8  <= s8_next;
      s9  <= s9_next;
      s10 <= s10_next;
      s11 <= s11_next;
      s12 <= s12_next;
      s13 <= s13_next;
      s14 <= s14_next;
      s15 <= s15_next;
      s16 <= s16_next;
      s17 <= s17_next;
      s18 <= s18_next;
    end
  end

  rbp_sqrt u_sqrt_gn (
    .clk (clk),
    .en  (en),
    .a   (s7.r[W-2:0]),
    .r   (gn)
  );

  rbp_delay #(.WIDTH($bits(side1_t)), .DEPTH(SR)) u_delay_gn (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7.v),
    .in_data   (d1_in),
    .out_valid (d1_valid),
    .out_data  (d1)
  );

  rbp_delay #(.WIDTH($bits(side2_t)), .DEPTH(rbp_pkg::DIV_LAT)) u_delay_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_valid),
    .in_data   (d2_in),
    .out_valid (d2_valid),
    .out_data  (d2)
  );

  rbp_delay #(.WIDTH($bits(side3_t)), .DEPTH(rbp_pkg::DIV_LAT)) u_delay_s (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s10.v),
    .in_data   (d3_in),
    .out_valid (d3_valid),
    .out_data  (d3)
  );

  rbp_sqrt u_sqrt_gam (
    .clk (clk),
    .en  (en),
    .a   (s16.r[W-2:0]),
    .r   (gam)
  );

  rbp_delay #(.WIDTH($bits(side4_t)), .DEPTH(SR)) u_delay_gam (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s16.v),
    .in_data   (d4_in),
    .out_valid (d4_valid),
    .out_data  (d4)
  );

  rbp_delay #(.WIDTH($bits(side5_t)), .DEPTH(rbp_pkg::DIV_LAT)) u_delay_pos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s17.v),
    .in_data   (d5_in),
    .out_valid (d5_valid),
    .out_data  (d5)
  );

  for (genvar d = 0; d < 3; d++) begin : g_lane
    rbp_div u_div_t (
      .clk (clk),
      .en  (en),
      .a   (d1.hb[d]),
      .b   ((W-1)'(gn)),
      .q   (t_q[d])
    );

    rbp_div u_div_s (
      .clk (clk),
      .en  (en),
      .a   (s10.t2[d]),
      .b   (s10.den[W-2:0]),
      .q   (s_q[d])
    );

    rbp_div u_div_pos (
      .clk (clk),
      .en  (en),
      .a   (s17.dtu[d]),
      .b   ((W-1)'(s17.gam)),
      .q   (q_q[d])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_full && out_ready) begin
      if (skid_full) begin
        out_reg   <= skid_reg;
        skid_full <= 1'b0;
      end else if (s18.v) begin
        out_reg <= s18.res;
      end else begin
        out_full <= 1'b0;
      end
    end else if (!out_full) begin
      if (s18.v) begin
        out_reg  <= s18.res;
        out_full <= 1'b1;
      end
    end else if (en && s18.v) begin
      skid_reg  <= s18.res;
      skid_full <= 1'b1;
    end
  end

  assign out_valid      = out_full;
  assign lorentz_factor = (W-1)'(out_reg.gam);
  assign new_vel_x      = out_reg.un[0];
  assign new_vel_y      = out_reg.un[1];
  assign new_vel_z      = out_reg.un[2];
  assign new_pos_x      = out_reg.np[0];
  assign new_pos_y      = out_reg.np[1];
  assign new_pos_z      = out_reg.np[2];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(out_full && !out_ready))
    else $error("skid register filled without a stalled output");

  a_gamma_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lorentz_factor >= (W-1)'(rbp_pkg::FX_ONE)))
    else $error("Lorentz factor below one");

endmodule

// ----- design/rbp_delay.sv -----
// ----------------------------------------------------------------------------
// rbp_delay
// Enabled delay line for item sideband data and its valid bit.
// ----------------------------------------------------------------------------
module rbp_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] data [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data[i] <= data[i-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule

// ----- design/rbp_div.sv -----
// ----------------------------------------------------------------------------
// rbp_div
// Pipelined restoring divider: (a * 2^F) / b for b > 0, rounded to nearest
// with ties away from zero, saturated. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rbp_div (
  input  logic                  clk,
  input  logic                  en,
  input  rbp_pkg::word_t        a,
  input  logic [rbp_pkg::W-2:0] b,
  output rbp_pkg::word_t        q
);

  localparam int W  = rbp_pkg::W;
  localparam int F  = rbp_pkg::F;
  localparam int NW = W + F + 1;

  logic [W-1:0]  mag;
  logic [NW-1:0] num;

  logic          neg_q  [W+1];
  logic          ovf_q  [W+1];
  logic [W-1:0]  lo_q   [W+1];
  logic [W-2:0]  rem_q  [W+1];
  logic [W-2:0]  dvs_q  [W+1];
  logic [W-1:0]  quo_q  [W+1];

  logic [W-2:0]  rem_next [W+1];
  logic [W-1:0]  quo_next [W+1];

  always_comb begin
    logic [W-1:0] r2;
    r2  = '0;
    mag = a[W-1] ? W'(-a) : W'(a);
    num = NW'({mag, {F{1'b0}}}) + NW'(b >> 1);
    rem_next[0] = (W-1)'(num[NW-1:W]);
    quo_next[0] = '0;
    for (int i = 1; i <= W; i++) begin
      r2 = {rem_q[i-1], lo_q[i-1][W-i]};
      if (r2 >= {1'b0, dvs_q[i-1]}) begin
        rem_next[i] = (W-1)'(r2 - {1'b0, dvs_q[i-1]});
        quo_next[i] = {quo_q[i-1][W-2:0], 1'b1};
      end else begin
        rem_next[i] = r2[W-2:0];
        quo_next[i] = {quo_q[i-1][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_q[0] <= a[W-1];
      ovf_q[0] <= (num[NW-1:W] >= b);
      lo_q[0]  <= num[W-1:0];
      dvs_q[0] <= b;
      for (int i = 0; i <= W; i++) begin
        rem_q[i] <= rem_next[i];
        quo_q[i] <= quo_next[i];
      end
      for (int i = 1; i <= W; i++) begin
        neg_q[i] <= neg_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
        lo_q[i]  <= lo_q[i-1];
        dvs_q[i] <= dvs_q[i-1];
      end
      if (ovf_q[W] || quo_q[W][W-1]) begin
        q <= neg_q[W] ? rbp_pkg::WORD_MIN : rbp_pkg::WORD_MAX;
      end else begin
        q <= neg_q[W] ? -signed'(quo_q[W]) : signed'(quo_q[W]);
      end
    end
  end

endmodule

// ----- design/rbp_sqrt.sv -----
// ----------------------------------------------------------------------------
// rbp_sqrt
// Pipelined integer square root: floor(sqrt(a * 2^F)) for a >= 0.
// One root bit per stage.
// ----------------------------------------------------------------------------
module rbp_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [rbp_pkg::W-2:0]  a,
  output logic [rbp_pkg::SR-1:0] r
);

  localparam int F   = rbp_pkg::F;
  localparam int SQW = rbp_pkg::SQW;
  localparam int SR  = rbp_pkg::SR;
  localparam int XW  = SQW + 2;

  logic [SQW-1:0] rem_q     [SR];
  logic [SR-1:0]  root_q    [SR];
  logic [SQW-1:0] rem_next  [SR];
  logic [SR-1:0]  root_next [SR];

  always_comb begin
    logic [SQW-1:0] rin;
    logic [SR-1:0]  root_in;
    logic [XW-1:0]  trial;
    int k;
    for (int i = 0; i < SR; i++) begin
      k = SR - 1 - i;
      if (i == 0) begin
        rin     = {a, {F{1'b0}}};
        root_in = '0;
      end else begin
        rin     = rem_q[i-1];
        root_in = root_q[i-1];
      end
      trial = (XW'(root_in) << (k + 1)) + (XW'(1) << (2 * k));
      if (trial <= XW'(rin)) begin
        rem_next[i]  = rin - trial[SQW-1:0];
        root_next[i] = root_in | (SR'(1) << k);
      end else begin
        rem_next[i]  = rin;
        root_next[i] = root_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SR; i++) begin
        rem_q[i]  <= rem_next[i];
        root_q[i] <= root_next[i];
      end
    end
  end

  assign r = root_q[SR-1];

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Boris push core testbench
// Streams particles through the pipelined relativistic Boris pusher under
// bursty input and a stalling receiver, predicts results with an independent
// fixed-point model or a row's given expectation, checks each field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef rbp_pkg::word_t word_t;
  localparam int W = rbp_pkg::W;
  localparam int F = rbp_pkg::F;

  typedef enum logic {REG_CHARGE_TO_MASS = 1'b0, REG_TIME_STEP = 1'b1} reg_index_e;

  localparam int   PIPE_DRAIN   = 160;
  localparam int   CYCLE_LIMIT  = 600000;
  localparam int   RANDOM_ITEMS = 1030;
  localparam word_t ONE_Q       = 32'sd65536;

  typedef struct {
    word_t u[3];
    word_t e[3];
    word_t b[3];
    word_t x[3];
  } particle_t;

  typedef struct {
    logic [W-2:0] gam;
    word_t        vel[3];
    word_t        pos[3];
  } push_result_t;

  typedef struct {
    particle_t    p;
    bit           typed;
    push_result_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_write_en = 1'b0;
  logic         cfg_index = 1'b0;
  logic [W-1:0] cfg_data = '0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  word_t        vel_x = '0, vel_y = '0, vel_z = '0;
  word_t        efield_x = '0, efield_y = '0, efield_z = '0;
  word_t        bfield_x = '0, bfield_y = '0, bfield_z = '0;
  word_t        pos_x = '0, pos_y = '0, pos_z = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-2:0] lorentz_factor;
  word_t        new_vel_x, new_vel_y, new_vel_z;
  word_t        new_pos_x, new_pos_y, new_pos_z;

  relativistic_boris_push_core uut (.*);

  always #5 clk = ~clk;

  longint       qm_mirror;
  longint       dt_mirror;
  push_result_t pending_pushes[$];
  stim_row_t    dir_rows[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  int           burst_left = 0;

  // -------- fixed-point predictor --------
  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return clamp_word(p >>> F);
  endfunction

  function automatic longint qdiv(longint a, longint d);
    longint num, q;
    num = a * 64'sd65536;
    if (num >= 0) q = (num + d / 2) / d;
    else q = -((-num + d / 2) / d);
    return clamp_word(q);
  endfunction

  function automatic longint qsqrt(longint a);
    longint unsigned rem, root, bitv;
    rem = (a < 0) ? 64'd0 : (longint'(a) << F);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return clamp_word(longint'(root));
  endfunction

  function automatic longint qdot(longint a[3], longint b[3]);
    longint acc;
    acc = qmul(a[0], b[0]);
    acc = clamp_word(acc + qmul(a[1], b[1]));
    return clamp_word(acc + qmul(a[2], b[2]));
  endfunction

  function automatic void qcross(input longint a[3], input longint b[3], output longint c[3]);
    c[0] = clamp_word(qmul(a[1], b[2]) - qmul(a[2], b[1]));
    c[1] = clamp_word(qmul(a[2], b[0]) - qmul(a[0], b[2]));
    c[2] = clamp_word(qmul(a[0], b[1]) - qmul(a[1], b[0]));
  endfunction

  function automatic push_result_t boris_step(particle_t p);
    longint       um[3], t[3], s[3], up[3], un[3], cr[3];
    longint       hh, gn, den, gam;
    push_result_t r;
    hh = qmul(qmul(qm_mirror, dt_mirror), 64'sd32768);
    for (int d = 0; d < 3; d++) um[d] = clamp_word(p.u[d] + qmul(p.e[d], hh));
    gn = qsqrt(clamp_word(64'sd65536 + qdot(um, um)));
    for (int d = 0; d < 3; d++) t[d] = qdiv(qmul(hh, p.b[d]), gn);
    den = clamp_word(64'sd65536 + qdot(t, t));
    for (int d = 0; d < 3; d++) s[d] = qdiv(qmul(64'sd131072, t[d]), den);
    qcross(um, t, cr);
    for (int d = 0; d < 3; d++) up[d] = clamp_word(um[d] + cr[d]);
    qcross(up, s, cr);
    for (int d = 0; d < 3; d++)
      un[d] = clamp_word(clamp_word(um[d] + cr[d]) + qmul(p.e[d], hh));
    gam = qsqrt(clamp_word(64'sd65536 + qdot(un, un)));
    r.gam = gam[W-2:0];
    for (int d = 0; d < 3; d++) begin
      r.vel[d] = word_t'(un[d]);
      r.pos[d] = word_t'(clamp_word(p.x[d] + qdiv(qmul(dt_mirror, un[d]), gam)));
    end
    return r;
  endfunction

  // -------- stimulus helpers --------
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2, 3: return word_t'($urandom);
      4: return word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return word_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff);
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    for (int d = 0; d < 3; d++) begin
      p.u[d] = rand_word();
      p.e[d] = rand_word();
      p.b[d] = rand_word();
      p.x[d] = rand_word();
    end
    return p;
  endfunction

  function automatic particle_t mk(word_t u0, u1, u2, e0, e1, e2, b0, b1, b2, x0, x1, x2);
    particle_t p;
    p.u = '{u0, u1, u2};
    p.e = '{e0, e1, e2};
    p.b = '{b0, b1, b2};
    p.x = '{x0, x1, x2};
    return p;
  endfunction

  // at rest with no field: the particle stays put with gamma one
  function automatic void add_rest_row(word_t x0, x1, x2);
    stim_row_t r;
    r.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, x0, x1, x2);
    r.typed = 1'b1;
    r.want.gam = ONE_Q[W-2:0];
    r.want.vel = '{0, 0, 0};
    r.want.pos = '{x0, x1, x2};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_row(particle_t p);
    stim_row_t r;
    r.p = p;
    r.typed = 1'b0;
    dir_rows.push_back(r);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s of result %0d: got %h, want %h",
             $realtime, field, results_seen, got, want);
    mismatches++;
  endtask

  task automatic write_reg(reg_index_e idx, logic [W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_CHARGE_TO_MASS) qm_mirror = longint'(word_t'(value));
    else dt_mirror = longint'(value[W-2:0]);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_particle(particle_t p, bit typed, push_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    {vel_x, vel_y, vel_z} <= {p.u[0], p.u[1], p.u[2]};
    {efield_x, efield_y, efield_z} <= {p.e[0], p.e[1], p.e[2]};
    {bfield_x, bfield_y, bfield_z} <= {p.b[0], p.b[1], p.b[2]};
    {pos_x, pos_y, pos_z} <= {p.x[0], p.x[1], p.x[2]};
    do @(posedge clk); while (!in_ready);
    pending_pushes.push_back(typed ? want : boris_step(p));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_pushes.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // -------- receiver stalls and result checking --------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    case ((cycle_count / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ((cycle_count % 37) > 24);
    endcase
  end

  always @(posedge clk) begin
    push_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pushes.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = pending_pushes.pop_front();
        if (lorentz_factor !== want.gam) report_mismatch("lorentz_factor", lorentz_factor, want.gam);
        if (new_vel_x !== want.vel[0]) report_mismatch("new_vel_x", new_vel_x, want.vel[0]);
        if (new_vel_y !== want.vel[1]) report_mismatch("new_vel_y", new_vel_y, want.vel[1]);
        if (new_vel_z !== want.vel[2]) report_mismatch("new_vel_z", new_vel_z, want.vel[2]);
        if (new_pos_x !== want.pos[0]) report_mismatch("new_pos_x", new_pos_x, want.pos[0]);
        if (new_pos_y !== want.pos[1]) report_mismatch("new_pos_y", new_pos_y, want.pos[1]);
        if (new_pos_z !== want.pos[2]) report_mismatch("new_pos_z", new_pos_z, want.pos[2]);
      end
      results_seen++;
    end
  end

  // -------- main sequence --------
  initial begin
    push_result_t none;
    word_t        mx, mn;
    int           phase_items;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    none = '{default: 0};
    qm_mirror = 64'sd65536;
    dt_mirror = 64'sd65536;

    add_rest_row(0, 0, 0);
    add_rest_row(mx, mn, -1);
    add_rest_row(mn, mx, 1);
    add_row(mk(mx, mx, mx, 0, 0, 0, 0, 0, 0, mx, mx, mx));
    add_row(mk(mn, mn, mn, 0, 0, 0, 0, 0, 0, mn, mn, mn));
    add_row(mk(0, 0, 0, mx, mx, mx, 0, 0, 0, 0, 0, 0));
    add_row(mk(0, 0, 0, mn, mn, mn, 0, 0, 0, 0, 0, 0));
    add_row(mk(ONE_Q, 0, 0, 0, 0, 0, mx, mx, mx, 0, 0, 0));
    add_row(mk(0, ONE_Q, 0, 0, 0, 0, mn, mn, mn, 0, 0, 0));
    add_row(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    add_row(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    add_row(mk(ONE_Q, 0, 0, 0, 0, 0, 0, 0, ONE_Q, 0, 0, 0));
    add_row(mk(0, 0, 0, ONE_Q, 2 * ONE_Q, -3 * ONE_Q, ONE_Q / 2, 0, -ONE_Q, 0, 0, 0));
    add_row(mk(3 * ONE_Q, -ONE_Q, 5, -2 * ONE_Q, 7, ONE_Q, 4 * ONE_Q, -4 * ONE_Q, 1,
               100, -100, 0));
    add_row(mk(-1, 1, -1, 1, -1, 1, -1, 1, -1, 1, -1, 1));
    add_row(mk(mx, 0, mn, 0, mx, 0, mn, 0, mx, 0, mn, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_particle(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].want);
    drain_pipeline();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CHARGE_TO_MASS, 32'h0001_0000);
          write_reg(REG_TIME_STEP, 32'h8000_4000);
        end
        1: begin
          write_reg(REG_CHARGE_TO_MASS, 32'h7fff_ffff);
          write_reg(REG_TIME_STEP, 32'hffff_ffff);
        end
        2: begin
          write_reg(REG_CHARGE_TO_MASS, 32'h8000_0000);
          write_reg(REG_TIME_STEP, 32'h0000_0000);
        end
        3: begin
          write_reg(REG_CHARGE_TO_MASS, 32'hffff_0000);
          write_reg(REG_TIME_STEP, 32'h0000_0001);
        end
        default: begin
          write_reg(REG_CHARGE_TO_MASS, $urandom);
          write_reg(REG_TIME_STEP, $urandom_range(0, 32'h3ffff) | ($urandom_range(0, 1) << 31));
        end
      endcase
      phase_items = (ph == 0 || ph >= 4) ? RANDOM_ITEMS / 4 : RANDOM_ITEMS / 12;
      for (int n = 0; n < phase_items; n++) send_particle(rand_particle(), 1'b0, none);
      drain_pipeline();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- relativistic_boris_push_core.f -----
design/rbp_pkg.sv
design/rbp_delay.sv
design/rbp_div.sv
design/rbp_sqrt.sv
design/relativistic_boris_push_core.sv
test/tb_top.sv
